// File: rtl/assert_macros.svh
// assertion helpers for the page frame manager
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define PFM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define PFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/pfm_pkg.sv
// ----------------------------------------------------------------------------
// pfm_pkg
// Types and constants shared by the page frame manager files.
// ----------------------------------------------------------------------------
package pfm_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int FRAMES        = 16;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int FR_W          = $clog2(FRAMES);
  localparam int CNT_W         = $clog2(FRAMES + 1);

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_LOAD    = 3'd1;
  localparam logic [2:0] OP_QUERY   = 3'd2;
  localparam logic [2:0] OP_WMARK   = 3'd3;
  localparam logic [2:0] OP_RELEASE = 3'd4;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND   = 2'd1;
  localparam logic [1:0] ST_FULL        = 2'd2;
  localparam logic [1:0] ST_NOT_PRESENT = 2'd3;

  localparam logic REG_FRAMES = 1'b0;
  localparam logic REG_SHIFT  = 1'b1;

  typedef struct packed {
    logic [15:0]     proc;
    logic [9:0]      page;
    logic [15:0]     swap;
    logic [FR_W-1:0] frame;
  } entry_t;

  typedef struct packed {
    logic        relv;
    logic [15:0] rel;
    logic [15:0] wbs;
    logic        wb;
    logic        ev;
    logic [15:0] fetch;
    logic [3:0]  frame;
    logic [1:0]  status;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CHK  = 5'b00010,
    S_VRD  = 5'b00100,
    S_VCHK = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  function automatic res_t mk_res(input logic [1:0] st);
    res_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

endpackage

// File: rtl/pfm_ram.sv
// ----------------------------------------------------------------------------
// pfm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/paged_frame_manager_fifo_top.sv
// ----------------------------------------------------------------------------
// paged_frame_manager_fifo_top
// Page table with frame allocation and FIFO replacement.
// ----------------------------------------------------------------------------
//  port group | dir | contents
//  in_*       | in  | one command word per operation
//  out_*      | out | result words, tlast on the final one of a command
//  cfg_*      | in  | register access, frames_in_use at 0, page_shift at 4
//
// A command walks the entry RAM one entry per cycle, set by the single read port
// of the entry RAM; a load with eviction adds the S_VRD and S_VCHK states for
// the victim read. Release stalls its walk while a result word waits.
// A new command is taken once the previous one has handed its last result to
// the output register. Reset is synchronous and needs no clearing pass.

`include "assert_macros.svh"

module paged_frame_manager_fifo_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // operation, process_id, page_number, swap_position, physical_address
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status, frame_number, fetch_swap_slot, evicted, writeback_needed,
  // writeback_swap_slot, released_swap_slot, released_valid
  output logic [63:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int N  = pfm_pkg::TABLE_ENTRIES;
  localparam int F  = pfm_pkg::FRAMES;
  localparam int IW = pfm_pkg::IDX_W;
  localparam int FW = pfm_pkg::FR_W;
  localparam int CW = pfm_pkg::CNT_W;

  pfm_pkg::state_t state_r, state_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [2:0]      op_r, op_nxt;
  logic [15:0]     pid_r, pid_nxt;
  logic [9:0]      page_r, page_nxt;
  logic [15:0]     swap_r, swap_nxt;
  logic [19:0]     addr_r, addr_nxt;
  logic [N-1:0]    valid_r, valid_nxt;
  logic [N-1:0]    pres_r, pres_nxt;
  logic [N-1:0]    mod_r, mod_nxt;
  logic [F-1:0]    busy_r, busy_nxt;
  logic [IW-1:0]   fifo_r [F];
  logic [IW-1:0]   fifo_nxt [F];
  logic [FW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  pfm_pkg::res_t   res_r, res_nxt;
  pfm_pkg::entry_t ent_r, ent_nxt;
  logic [15:0]     pend_r, pend_nxt;
  logic            pend_vld_r, pend_vld_nxt;
  logic            out_tvalid_r, out_tvalid_nxt;
  pfm_pkg::res_t   out_res_r, out_res_nxt;
  logic            out_last_r, out_last_nxt;
  logic [4:0]      fiu_r, psh_r;

  logic            ram_we;
  logic [IW-1:0]   ram_waddr, ram_raddr;
  pfm_pkg::entry_t ram_wdata, ent;
  logic [$bits(pfm_pkg::entry_t)-1:0] ram_rdata;

  pfm_ram #(.WIDTH($bits(pfm_pkg::entry_t)), .DEPTH(N)) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ent = pfm_pkg::entry_t'(ram_rdata);

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == pfm_pkg::REG_SHIFT) ? {27'd0, psh_r} : {27'd0, fiu_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fiu_r <= 5'd16;
      psh_r <= 5'd12;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      if (cfg_paddr[2] == pfm_pkg::REG_SHIFT) begin
        psh_r <= cfg_pwdata[4:0];
      end else begin
        fiu_r <= cfg_pwdata[4:0];
      end
    end
  end

  // lowest free frame among the active ones
  logic [4:0]    n_act;
  logic          free_ok;
  logic [FW-1:0] free_f;

  always_comb begin
    if (fiu_r == 5'd0) begin
      n_act = 5'd1;
    end else if (32'(fiu_r) > F) begin
      n_act = 5'(F);
    end else begin
      n_act = fiu_r;
    end
    free_ok = 1'b0;
    free_f  = '0;
    for (int f = F - 1; f >= 0; f--) begin
      if (32'(n_act) > f && !busy_r[f]) begin
        free_ok = 1'b1;
        free_f  = FW'(f);
      end
    end
  end

  // fifo with one entry taken out, rebuilt from position zero
  logic [IW-1:0] lin [F];
  logic [IW-1:0] rem [F];
  logic          rem_found;
  logic [FW-1:0] rem_pos;

  always_comb begin
    for (int i = 0; i < F; i++) begin
      lin[i] = fifo_r[head_r + FW'(i)];
    end
    rem_found = 1'b0;
    rem_pos   = '0;
    for (int i = F - 1; i >= 0; i--) begin
      if (32'(count_r) > i && lin[i] == idx_r) begin
        rem_found = 1'b1;
        rem_pos   = FW'(i);
      end
    end
    for (int i = 0; i < F; i++) begin
      if (rem_found && FW'(i) >= rem_pos && i < F - 1) begin
        rem[i] = lin[(i + 1) % F];
      end else begin
        rem[i] = lin[i];
      end
    end
  end

  logic [19:0]   wm_frame;
  logic          m_pp, m_proc, m_wm, last_idx, out_free;
  logic [IW-1:0] victim;

  assign wm_frame = addr_r >> psh_r;
  assign m_proc   = valid_r[idx_r] && (ent.proc == pid_r);
  assign m_pp     = m_proc && (ent.page == page_r);
  assign m_wm     = valid_r[idx_r] && pres_r[idx_r] &&
                    ({{(20 - FW){1'b0}}, ent.frame} == wm_frame);
  assign last_idx = (idx_r == IW'(N - 1));
  assign out_free = !out_tvalid_r || out_tready;
  assign victim   = fifo_r[head_r];

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    op_nxt         = op_r;
    pid_nxt        = pid_r;
    page_nxt       = page_r;
    swap_nxt       = swap_r;
    addr_nxt       = addr_r;
    valid_nxt      = valid_r;
    pres_nxt       = pres_r;
    mod_nxt        = mod_r;
    busy_nxt       = busy_r;
    fifo_nxt       = fifo_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    res_nxt        = res_r;
    ent_nxt        = ent_r;
    pend_nxt       = pend_r;
    pend_vld_nxt   = pend_vld_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_res_nxt    = out_res_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = ent_r;
    ram_raddr      = '0;

    unique case (state_r)
      pfm_pkg::S_IDLE: begin
        if (in_tvalid) begin
          op_nxt       = in_tdata[2:0];
          pid_nxt      = in_tdata[18:3];
          page_nxt     = in_tdata[28:19];
          swap_nxt     = in_tdata[44:29];
          addr_nxt     = in_tdata[64:45];
          idx_nxt      = '0;
          pend_vld_nxt = 1'b0;
          if (in_tdata[2:0] > pfm_pkg::OP_RELEASE) begin
            res_nxt   = pfm_pkg::mk_res(pfm_pkg::ST_NOT_FOUND);
            state_nxt = pfm_pkg::S_FIN;
          end else begin
            state_nxt = pfm_pkg::S_CHK;
          end
        end
      end

      pfm_pkg::S_CHK: begin
        ram_raddr = idx_r;
        unique case (op_r)
          pfm_pkg::OP_ADD: begin
            if (!valid_r[idx_r]) begin
              ram_we          = 1'b1;
              ram_wdata.proc  = pid_r;
              ram_wdata.page  = page_r;
              ram_wdata.swap  = swap_r;
              ram_wdata.frame = '0;
              valid_nxt[idx_r] = 1'b1;
              pres_nxt[idx_r]  = 1'b0;
              mod_nxt[idx_r]   = 1'b0;
              res_nxt   = pfm_pkg::mk_res(pfm_pkg::ST_OK);
              state_nxt = pfm_pkg::S_FIN;
            end else if (last_idx) begin
              res_nxt   = pfm_pkg::mk_res(pfm_pkg::ST_FULL);
              state_nxt = pfm_pkg::S_FIN;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              ram_raddr = idx_r + 1'b1;
            end
          end
          pfm_pkg::OP_LOAD: begin
            if (m_pp) begin
              ent_nxt = ent;
              if (pres_r[idx_r]) begin
                res_nxt       = pfm_pkg::mk_res(pfm_pkg::ST_OK);
                res_nxt.frame = 4'(ent.frame);
                state_nxt     = pfm_pkg::S_FIN;
              end else if (free_ok) begin
                busy_nxt[free_f] = 1'b1;
                pres_nxt[idx_r]  = 1'b1;
                mod_nxt[idx_r]   = 1'b0;
                ram_we           = 1'b1;
                ram_wdata        = ent;
                ram_wdata.frame  = free_f;
                if (32'(count_r) < F) begin
                  fifo_nxt[head_r + count_r[FW-1:0]] = idx_r;
                  count_nxt = count_r + 1'b1;
                end
                res_nxt       = pfm_pkg::mk_res(pfm_pkg::ST_OK);
                res_nxt.frame = 4'(free_f);
                res_nxt.fetch = ent.swap;
                state_nxt     = pfm_pkg::S_FIN;
              end else if (count_r == '0) begin
                res_nxt   = pfm_pkg::mk_res(pfm_pkg::ST_FULL);
                state_nxt = pfm_pkg::S_FIN;
              end else begin
                state_nxt = pfm_pkg::S_VRD;
              end
            end else if (last_idx) begin
              res_nxt   = pfm_pkg::mk_res(pfm_pkg::ST_NOT_FOUND);
              state_nxt = pfm_pkg::S_FIN;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              ram_raddr = idx_r + 1'b1;
            end
          end
          pfm_pkg::OP_QUERY: begin
            if (m_pp) begin
              if (pres_r[idx_r]) begin
                res_nxt       = pfm_pkg::mk_res(pfm_pkg::ST_OK);
                res_nxt.frame = 4'(ent.frame);
              end else begin
                res_nxt = pfm_pkg::mk_res(pfm_pkg::ST_NOT_PRESENT);
              end
              state_nxt = pfm_pkg::S_FIN;
            end else if (last_idx) begin
              res_nxt   = pfm_pkg::mk_res(pfm_pkg::ST_NOT_FOUND);
              state_nxt = pfm_pkg::S_FIN;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              ram_raddr = idx_r + 1'b1;
            end
          end
          pfm_pkg::OP_WMARK: begin
            if (m_wm) begin
              mod_nxt[idx_r] = 1'b1;
              res_nxt        = pfm_pkg::mk_res(pfm_pkg::ST_OK);
              res_nxt.frame  = wm_frame[3:0];
              state_nxt      = pfm_pkg::S_FIN;
            end else if (last_idx) begin
              res_nxt   = pfm_pkg::mk_res(pfm_pkg::ST_NOT_FOUND);
              state_nxt = pfm_pkg::S_FIN;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              ram_raddr = idx_r + 1'b1;
            end
          end
          pfm_pkg::OP_RELEASE: begin
            if (m_proc) begin
              // hold the walk while the previous freed slot cannot leave
              if (!pend_vld_r || out_free) begin
                if (pend_vld_r) begin
                  out_tvalid_nxt   = 1'b1;
                  out_res_nxt      = '0;
                  out_res_nxt.rel  = pend_r;
                  out_res_nxt.relv = 1'b1;
                  out_last_nxt     = 1'b0;
                end
                pend_nxt     = ent.swap;
                pend_vld_nxt = 1'b1;
                if (pres_r[idx_r]) begin
                  busy_nxt[ent.frame] = 1'b0;
                  fifo_nxt  = rem;
                  head_nxt  = '0;
                  count_nxt = count_r - CW'(rem_found);
                end
                valid_nxt[idx_r] = 1'b0;
                pres_nxt[idx_r]  = 1'b0;
                mod_nxt[idx_r]   = 1'b0;
                if (last_idx) begin
                  res_nxt      = '0;
                  res_nxt.rel  = ent.swap;
                  res_nxt.relv = 1'b1;
                  state_nxt    = pfm_pkg::S_FIN;
                end else begin
                  idx_nxt   = idx_r + 1'b1;
                  ram_raddr = idx_r + 1'b1;
                end
              end
            end else if (last_idx) begin
              if (pend_vld_r) begin
                res_nxt      = '0;
                res_nxt.rel  = pend_r;
                res_nxt.relv = 1'b1;
              end else begin
                res_nxt = pfm_pkg::mk_res(pfm_pkg::ST_NOT_FOUND);
              end
              state_nxt = pfm_pkg::S_FIN;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              ram_raddr = idx_r + 1'b1;
            end
          end
          default: begin
            res_nxt   = pfm_pkg::mk_res(pfm_pkg::ST_NOT_FOUND);
            state_nxt = pfm_pkg::S_FIN;
          end
        endcase
      end

      pfm_pkg::S_VRD: begin
        ram_raddr = victim;
        state_nxt = pfm_pkg::S_VCHK;
      end

      pfm_pkg::S_VCHK: begin
        // pop the head and push the loaded entry, count stays
        ram_raddr         = victim;
        pres_nxt[victim]  = 1'b0;
        mod_nxt[victim]   = 1'b0;
        head_nxt          = head_r + 1'b1;
        fifo_nxt[head_r + count_r[FW-1:0]] = idx_r;
        busy_nxt[ent.frame] = 1'b1;
        pres_nxt[idx_r]   = 1'b1;
        mod_nxt[idx_r]    = 1'b0;
        ram_we            = 1'b1;
        ram_wdata         = ent_r;
        ram_wdata.frame   = ent.frame;
        res_nxt           = pfm_pkg::mk_res(pfm_pkg::ST_OK);
        res_nxt.frame     = 4'(ent.frame);
        res_nxt.fetch     = ent_r.swap;
        res_nxt.ev        = 1'b1;
        if (pres_r[victim] && mod_r[victim]) begin
          res_nxt.wb  = 1'b1;
          res_nxt.wbs = ent.swap;
        end
        state_nxt = pfm_pkg::S_FIN;
      end

      pfm_pkg::S_FIN: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_res_nxt    = res_r;
          out_last_nxt   = 1'b1;
          state_nxt      = pfm_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = pfm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pfm_pkg::S_IDLE;
      valid_r      <= '0;
      pres_r       <= '0;
      mod_r        <= '0;
      busy_r       <= '0;
      head_r       <= '0;
      count_r      <= '0;
      pend_vld_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      pres_r       <= pres_nxt;
      mod_r        <= mod_nxt;
      busy_r       <= busy_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      pend_vld_r   <= pend_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    op_r       <= op_nxt;
    pid_r      <= pid_nxt;
    page_r     <= page_nxt;
    swap_r     <= swap_nxt;
    addr_r     <= addr_nxt;
    fifo_r     <= fifo_nxt;
    res_r      <= res_nxt;
    ent_r      <= ent_nxt;
    pend_r     <= pend_nxt;
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready  = (state_r == pfm_pkg::S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_res_r};
  assign out_tlast  = out_last_r;

  `PFM_ASSERT_ALWAYS(a_fifo_tracks_present, 32'(count_r) == $countones(pres_r),
                     "fifo count differs from number of present entries")
  `PFM_ASSERT_ALWAYS(a_present_valid, (pres_r & ~valid_r) == '0,
                     "present entry is not valid")
  `PFM_ASSERT_ALWAYS(a_modified_present, (mod_r & ~pres_r) == '0,
                     "modified entry is not present")
  `PFM_ASSERT_NEXT(a_accept_leaves_idle, in_tvalid && in_tready,
                   state_r != pfm_pkg::S_IDLE, "command accepted but walk not started")

endmodule

// File: tb/sv/pfm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfm_checker
// Watches the command, result and register ports of the page frame manager,
// keeps its own copy of the page table, frame map and replacement queue, and
// compares every result word against the predicted one.
// ----------------------------------------------------------------------------
module pfm_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          mismatches,
  output int          pending
);

  localparam int NE = pfm_pkg::TABLE_ENTRIES;
  localparam int NF = pfm_pkg::FRAMES;

  typedef struct packed {
    logic          last;
    pfm_pkg::res_t r;
  } word_t;

  logic        pt_valid   [NE];
  logic [15:0] pt_proc    [NE];
  logic [9:0]  pt_page    [NE];
  logic [15:0] pt_swap    [NE];
  logic        pt_present [NE];
  logic        pt_dirty   [NE];
  logic [3:0]  pt_frame   [NE];
  logic        busy       [NF];
  logic [5:0]  rq_slot    [NF];
  int          rq_head, rq_count;
  logic [4:0]  n_frames, shift;
  word_t       exp_words[$];

  function automatic word_t one_word(logic [1:0] st, logic [3:0] fr, logic [15:0] fetch,
                                     logic ev, logic wb, logic [15:0] wbs);
    word_t w;
    w = '0;
    w.r.status = st;
    w.r.frame = fr;
    w.r.fetch = fetch;
    w.r.ev = ev;
    w.r.wb = wb;
    w.r.wbs = wbs;
    w.last = 1'b1;
    return w;
  endfunction

  // single word carrying only a status
  function automatic word_t status_word(logic [1:0] st);
    return one_word(st, '0, '0, 1'b0, 1'b0, '0);
  endfunction

  function automatic int lookup(logic [15:0] pid, logic [9:0] pg);
    for (int i = 0; i < NE; i++)
      if (pt_valid[i] && pt_proc[i] == pid && pt_page[i] == pg) return i;
    return -1;
  endfunction

  // drop one entry from the replacement queue and compact it to slot 0
  task automatic queue_drop(int idx);
    logic [5:0] keep [NF];
    int n;
    n = 0;
    for (int i = 0; i < rq_count; i++) begin
      if (rq_slot[(rq_head + i) % NF] != idx) begin
        keep[n] = rq_slot[(rq_head + i) % NF];
        n++;
      end
    end
    for (int i = 0; i < NF; i++) rq_slot[i] = (i < n) ? keep[i] : '0;
    rq_head = 0;
    rq_count = n;
  endtask

  task automatic predict_cmd(logic [71:0] w);
    logic [2:0]  op;
    logic [15:0] pid, swp;
    logic [9:0]  pg;
    logic [19:0] addr;
    logic [63:0] fnum;
    int e, nf, fr, v, k;
    logic got, ev, wb;
    logic [15:0] wbs;
    word_t x;
    op = w[2:0];
    pid = w[18:3];
    pg = w[28:19];
    swp = w[44:29];
    addr = w[64:45];
    unique case (op)
      pfm_pkg::OP_ADD: begin
        e = -1;
        for (int i = 0; i < NE; i++)
          if (e < 0 && !pt_valid[i]) e = i;
        if (e < 0) exp_words.push_back(status_word(pfm_pkg::ST_FULL));
        else begin
          pt_valid[e] = 1'b1;
          pt_proc[e] = pid;
          pt_page[e] = pg;
          pt_swap[e] = swp;
          pt_present[e] = 1'b0;
          pt_dirty[e] = 1'b0;
          pt_frame[e] = '0;
          exp_words.push_back(status_word(pfm_pkg::ST_OK));
        end
      end
      pfm_pkg::OP_LOAD: begin
        e = lookup(pid, pg);
        if (e < 0) exp_words.push_back(status_word(pfm_pkg::ST_NOT_FOUND));
        else if (pt_present[e])
          exp_words.push_back(one_word(pfm_pkg::ST_OK, pt_frame[e], '0, 1'b0, 1'b0, '0));
        else begin
          nf = (n_frames == 5'd0) ? 1 : (32'(n_frames) > NF) ? NF : 32'(n_frames);
          got = 1'b0; ev = 1'b0; wb = 1'b0; wbs = '0; fr = 0;
          for (int f = 0; f < nf; f++)
            if (!got && !busy[f]) begin
              fr = f;
              got = 1'b1;
            end
          if (!got && rq_count == 0) exp_words.push_back(status_word(pfm_pkg::ST_FULL));
          else begin
            if (!got) begin
              v = rq_slot[rq_head];
              rq_head = (rq_head + 1) % NF;
              rq_count--;
              ev = 1'b1;
              if (pt_present[v] && pt_dirty[v]) begin
                wb = 1'b1;
                wbs = pt_swap[v];
              end
              fr = pt_frame[v];
              pt_present[v] = 1'b0;
              pt_dirty[v] = 1'b0;
            end
            busy[fr] = 1'b1;
            pt_present[e] = 1'b1;
            pt_dirty[e] = 1'b0;
            pt_frame[e] = 4'(fr);
            if (rq_count < NF) begin
              rq_slot[(rq_head + rq_count) % NF] = 6'(e);
              rq_count++;
            end
            exp_words.push_back(one_word(pfm_pkg::ST_OK, 4'(fr), pt_swap[e], ev, wb, wbs));
          end
        end
      end
      pfm_pkg::OP_QUERY: begin
        e = lookup(pid, pg);
        if (e < 0) exp_words.push_back(status_word(pfm_pkg::ST_NOT_FOUND));
        else if (!pt_present[e]) exp_words.push_back(status_word(pfm_pkg::ST_NOT_PRESENT));
        else exp_words.push_back(one_word(pfm_pkg::ST_OK, pt_frame[e], '0, 1'b0, 1'b0, '0));
      end
      pfm_pkg::OP_WMARK: begin
        fnum = 64'(addr) >> shift;
        e = -1;
        for (int i = 0; i < NE; i++)
          if (e < 0 && pt_valid[i] && pt_present[i] && 64'(pt_frame[i]) == fnum) e = i;
        if (e < 0) exp_words.push_back(status_word(pfm_pkg::ST_NOT_FOUND));
        else begin
          pt_dirty[e] = 1'b1;
          exp_words.push_back(one_word(pfm_pkg::ST_OK, fnum[3:0], '0, 1'b0, 1'b0, '0));
        end
      end
      pfm_pkg::OP_RELEASE: begin
        k = 0;
        for (int i = 0; i < NE; i++) begin
          if (pt_valid[i] && pt_proc[i] == pid) begin
            if (pt_present[i]) begin
              busy[pt_frame[i]] = 1'b0;
              queue_drop(i);
            end
            pt_valid[i] = 1'b0;
            pt_present[i] = 1'b0;
            pt_dirty[i] = 1'b0;
            x = '0;
            x.r.rel = pt_swap[i];
            x.r.relv = 1'b1;
            exp_words.push_back(x);
            k++;
          end
        end
        if (k == 0) exp_words.push_back(status_word(pfm_pkg::ST_NOT_FOUND));
        else begin
          x = exp_words.pop_back();
          x.last = 1'b1;
          exp_words.push_back(x);
        end
      end
      default: exp_words.push_back(status_word(pfm_pkg::ST_NOT_FOUND));
    endcase
  endtask

  always @(posedge clk) begin
    word_t want;
    pfm_pkg::res_t got;
    if (!rst_n) begin
      for (int i = 0; i < NE; i++) begin
        pt_valid[i] = 1'b0;
        pt_present[i] = 1'b0;
        pt_dirty[i] = 1'b0;
      end
      for (int i = 0; i < NF; i++) begin
        busy[i] = 1'b0;
        rq_slot[i] = '0;
      end
      rq_head = 0;
      rq_count = 0;
      n_frames = 5'd16;
      shift = 5'd12;
      exp_words.delete();
      mismatches = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == pfm_pkg::REG_SHIFT) shift = cfg_pwdata[4:0];
        else n_frames = cfg_pwdata[4:0];
      end
      if (out_tvalid && out_tready) begin
        got = pfm_pkg::res_t'(out_tdata[$bits(pfm_pkg::res_t)-1:0]);
        if (exp_words.size() == 0) begin
          $display("%0t: unexpected result word %h last %b", $time, out_tdata, out_tlast);
          mismatches++;
        end else begin
          want = exp_words.pop_front();
          if (got !== want.r || out_tlast !== want.last ||
              out_tdata[63:$bits(pfm_pkg::res_t)] !== '0) begin
            $display("%0t: result mismatch expected %h last %b, actual %h last %b",
                     $time, want.r, want.last, out_tdata, out_tlast);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) predict_cmd(in_tdata);
    end
    pending = exp_words.size();
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the page frame manager: a directed run over every command and
// corner, then random command mixes under several register settings, with
// random gaps on the command side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LIMIT = 2_000_000;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [71:0] in_tdata;
  logic        out_tvalid, out_tready, out_tlast;
  logic [63:0] out_tdata;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  int          mismatches, pending, stall_left;
  int          cycles = 0;
  logic        no_idle;
  logic [4:0]  cur_shift;
  logic [15:0] pid_pool [4];

  paged_frame_manager_fifo_top u_top (.*);

  pfm_checker u_chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .out_tlast, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_pready, .mismatches, .pending
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side back-pressure, a fresh stall drawn per word
  always @(posedge clk) begin
    int gap;
    if (!rst_n) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (out_tready && out_tvalid) begin
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        stall_left <= gap;
        out_tready <= 1'b0;
      end
    end else if (stall_left > 1) stall_left <= stall_left - 1;
    else begin
      stall_left <= 0;
      out_tready <= 1'b1;
    end
  end

  task automatic send_word(logic [2:0] op, logic [15:0] pid, logic [9:0] pg,
                           logic [15:0] swp, logic [19:0] addr);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, addr, swp, pg, pid, op};
    do @(posedge clk); while (!in_tready);
  endtask

  // hold off until every result is back, then let the last command drain
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [4:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= {27'd0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(logic [4:0] nfr, logic [4:0] sh);
    drain();
    reg_write({pfm_pkg::REG_FRAMES, 2'b00}, nfr);
    reg_write({pfm_pkg::REG_SHIFT, 2'b00}, sh);
    cur_shift = sh;
  endtask

  task automatic random_cmd();
    logic [15:0] pid;
    logic [9:0]  pg;
    logic [19:0] addr;
    int pick;
    pid = ($urandom_range(0, 15) == 0) ? 16'($urandom) : pid_pool[$urandom_range(0, 3)];
    pg = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 7));
    addr = ($urandom_range(0, 3) == 0) ? 20'($urandom) :
           20'((64'($urandom_range(0, 15)) << cur_shift) | (64'($urandom) & 64'hff));
    pick = $urandom_range(0, 99);
    if (pick < 25) send_word(pfm_pkg::OP_ADD, pid, pg, 16'($urandom), addr);
    else if (pick < 55) send_word(pfm_pkg::OP_LOAD, pid, pg, 16'($urandom), addr);
    else if (pick < 70) send_word(pfm_pkg::OP_QUERY, pid, pg, 16'($urandom), addr);
    else if (pick < 88) send_word(pfm_pkg::OP_WMARK, pid, pg, 16'($urandom), addr);
    else if (pick < 97) send_word(pfm_pkg::OP_RELEASE, pid, pg, 16'($urandom), addr);
    else send_word(3'($urandom_range(5, 7)), pid, pg, 16'($urandom), addr);
  endtask

  initial begin
    rst_n = 0;
    no_idle = 0;
    cur_shift = 5'd12;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    pid_pool = '{16'd0, 16'hffff, 16'd1, 16'($urandom)};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_regs(5'd16, 5'd12);
    send_word(pfm_pkg::OP_ADD, 16'd0, 10'd0, 16'd0, 20'd0);
    send_word(pfm_pkg::OP_ADD, 16'hffff, 10'h3ff, 16'hffff, 20'hfffff);
    send_word(pfm_pkg::OP_ADD, 16'd1, 10'd5, 16'h1234, 20'd0);
    send_word(pfm_pkg::OP_ADD, 16'd1, 10'd5, 16'h4321, 20'd0);  // duplicate entry
    send_word(pfm_pkg::OP_LOAD, 16'd0, 10'd0, 16'd0, 20'd0);
    send_word(pfm_pkg::OP_LOAD, 16'd0, 10'd0, 16'd0, 20'd0);      // already present
    send_word(pfm_pkg::OP_LOAD, 16'd7, 10'd9, 16'd0, 20'd0);      // missing
    send_word(pfm_pkg::OP_QUERY, 16'hffff, 10'h3ff, 16'd0, 20'd0);
    send_word(pfm_pkg::OP_LOAD, 16'hffff, 10'h3ff, 16'd0, 20'd0);
    send_word(pfm_pkg::OP_QUERY, 16'hffff, 10'h3ff, 16'd0, 20'd0);
    send_word(pfm_pkg::OP_QUERY, 16'd2, 10'd2, 16'd0, 20'd0);
    send_word(pfm_pkg::OP_WMARK, 16'd0, 10'd0, 16'd0, 20'h00fff);
    send_word(pfm_pkg::OP_WMARK, 16'd0, 10'd0, 16'd0, 20'hfffff);
    send_word(3'd5, 16'd0, 10'd0, 16'd0, 20'd0);
    send_word(3'd6, 16'd0, 10'd0, 16'd0, 20'd0);
    send_word(3'd7, 16'hffff, 10'h3ff, 16'hffff, 20'hfffff);
    send_word(pfm_pkg::OP_RELEASE, 16'd1, 10'd0, 16'd0, 20'd0);
    send_word(pfm_pkg::OP_RELEASE, 16'd123, 10'd0, 16'd0, 20'd0);
    send_word(pfm_pkg::OP_LOAD, 16'd1, 10'd5, 16'd0, 20'd0);
    send_word(pfm_pkg::OP_RELEASE, 16'hffff, 10'd0, 16'd0, 20'd0);

    // register sweeps, small frame counts force eviction
    set_regs(5'd1, 5'd0);
    repeat (20) random_cmd();
    set_regs(5'd4, 5'd16);
    no_idle = 1;
    repeat (10) random_cmd();
    no_idle = 0;
    repeat (10) random_cmd();
    set_regs(5'd0, 5'd31);
    repeat (12) random_cmd();
    set_regs(5'd31, 5'd8);
    repeat (15) random_cmd();

    // fill the table past full, then release the pooled processes in bulk
    set_regs(5'd16, 5'd12);
    repeat (68) send_word(pfm_pkg::OP_ADD, pid_pool[$urandom_range(0, 3)], 10'($urandom),
                          16'($urandom), 20'($urandom));
    repeat (10) random_cmd();
    for (int i = 0; i < 4; i++) send_word(pfm_pkg::OP_RELEASE, pid_pool[i], 10'd0, 16'd0, 20'd0);

    drain();
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/pfm_pkg.sv
rtl/pfm_ram.sv
rtl/paged_frame_manager_fifo_top.sv
tb/sv/pfm_checker.sv
tb/sv/tb_top.sv
